### rtl/core/mtt_pkg.sv
// shared types, codes and helpers for the text tokenizer
package mtt_pkg;

   // line counter width default and reported line width
   localparam int LINE_BITS_DEF = 32;
   localparam int LINE_W        = 32;

   // entries in the front-to-back queue
   localparam int QUEUE_DEPTH = 4;

   // most result items one input byte can cause
   localparam int MAX_EV = 4;

   // character codes
   localparam logic [7:0] CH_EOT     = 8'h00;
   localparam logic [7:0] CH_NL      = 8'h0a;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] CH_SLASH   = 8'h2f;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_LBRACE  = 8'h7b;
   localparam logic [7:0] CH_RBRACE  = 8'h7d;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_LBRACK  = 8'h5b;
   localparam logic [7:0] CH_RBRACK  = 8'h5d;

   // event codes
   localparam logic [1:0] EV_BEGIN   = 2'd0;
   localparam logic [1:0] EV_CONTENT = 2'd1;
   localparam logic [1:0] EV_END     = 2'd2;
   localparam logic [1:0] EV_EOT     = 2'd3;

   // token kinds
   localparam logic [2:0] KIND_WORD   = 3'd0;
   localparam logic [2:0] KIND_QUOTED = 3'd1;
   localparam logic [2:0] KIND_LBRACE = 3'd2;
   localparam logic [2:0] KIND_RBRACE = 3'd3;
   localparam logic [2:0] KIND_LPAREN = 3'd4;
   localparam logic [2:0] KIND_RPAREN = 3'd5;
   localparam logic [2:0] KIND_LBRACK = 3'd6;
   localparam logic [2:0] KIND_RBRACK = 3'd7;

   // one result item without line and last
   typedef struct packed {
      logic [1:0] event_res;
      logic [2:0] token_kind;
      logic [7:0] data;
   } entry_type;

   // all results of one input byte
   typedef struct packed {
      entry_type [MAX_EV-1:0] ent;
      logic [2:0]             count;
      logic [LINE_W-1:0]      line;
   } bundle_type;

   // queue status seen by the front
   typedef struct packed {
      logic full;
   } q_status_type;

   // c-locale whitespace
   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // bracket kind, word kind when not a bracket
   function automatic logic [2:0] bracket_kind(input logic [7:0] c);
      logic [2:0] k;
      k = KIND_WORD;
      unique case (c)
         CH_LBRACE: k = KIND_LBRACE;
         CH_RBRACE: k = KIND_RBRACE;
         CH_LPAREN: k = KIND_LPAREN;
         CH_RPAREN: k = KIND_RPAREN;
         CH_LBRACK: k = KIND_LBRACK;
         CH_RBRACK: k = KIND_RBRACK;
         default:   k = KIND_WORD;
      endcase
      return k;
   endfunction

endpackage

### rtl/core/map_text_tokenizer.sv
// top level of the byte-serial text tokenizer
//
//  port group   dir  payload
//  req_*        in   tdata[7:0] ch
//  rsp_*        out  tdata[7:0] data, [39:8] line; tuser[1:0] event_res,
//                    [4:2] token_kind; tlast last
//  csr_*        in   wdata[0] first_line (also loads the line counter)
//
// one source byte is taken per cycle while the four-entry bundle queue has room
// each byte yields zero to four result items, sent one per cycle from the back
// while rsp_tready is high; sustained rate is one byte per cycle for bytes with at
// most one result, otherwise the back end's one-item-per-cycle output sets the pace
// synchronous reset returns to idle with line counter 1; a result item is registered
// in the bundle queue and then in the output register, and holds while rsp_tready is low
module map_text_tokenizer import mtt_pkg::*; #(
   parameter int LINE_BITS = LINE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // data, line
   output logic [4:0]  rsp_tuser,   // event_res, token_kind
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [0:0]  csr_wdata
);

   q_status_type q_status;
   logic         q_push;
   bundle_type   push_bundle;
   logic         q_pop;
   logic         q_valid;
   logic [$bits(bundle_type)-1:0] head_bits;
   bundle_type   head_bundle;

   assign head_bundle = bundle_type'(head_bits);

   // front end: classify bytes
   mtt_front #(
      .LINE_BITS (LINE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_bundle   (push_bundle)
   );

   // bundle queue
   mtt_queue #(
      .WIDTH ($bits(bundle_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (push_bundle),
      .status (q_status),
      .pop    (q_pop),
      .rvalid (q_valid),
      .rdata  (head_bits)
   );

   // back end: emit result items
   mtt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_bundle   (head_bundle),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/core/mtt_queue.sv
// small register fifo between front and back
module mtt_queue import mtt_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output q_status_type     status,
   input  logic             pop,
   output logic             rvalid,
   output logic [WIDTH-1:0] rdata
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push     = push && !status.full;
   assign do_pop      = pop && rvalid;
   assign status.full = (count_ff == CNT_W'(DEPTH));
   assign rvalid      = (count_ff != '0);
   assign rdata       = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### rtl/core/mtt_front.sv
// front: takes source bytes, tracks mode and line, builds result bundles
module mtt_front import mtt_pkg::*; #(
   parameter int LINE_BITS = LINE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         csr_wen,
   input  logic [0:0]   csr_wdata,
   input  q_status_type q_status,
   output logic         q_push,
   output bundle_type   q_bundle
);

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_SLASH   = 3'd1;
   localparam logic [2:0] MODE_COMMENT = 3'd2;
   localparam logic [2:0] MODE_WORD    = 3'd3;
   localparam logic [2:0] MODE_QUOTED  = 3'd4;

   logic [2:0]           mode_ff, mode_in;
   logic [LINE_BITS-1:0] line_ff, line_in;
   logic [LINE_W-1:0]    line_rep;
   logic                 accept;
   logic                 nl;
   logic                 do_word;
   logic [2:0]           n;
   entry_type [MAX_EV-1:0] ent;
   logic [7:0]           c;
   logic [2:0]           bk;

   assign c          = req_tdata;
   assign bk         = bracket_kind(c);
   assign req_tready = !q_status.full;
   assign accept     = req_tvalid && req_tready;

   // reported line, clamped to the output width
   generate
      if (LINE_BITS > LINE_W) begin : g_clamp
         assign line_rep = (|line_ff[LINE_BITS-1:LINE_W]) ? '1 : line_ff[LINE_W-1:0];
      end else begin : g_ext
         assign line_rep = LINE_W'(line_ff);
      end
   endgenerate

   // per-byte decode into up to four result items
   always_comb begin
      mode_in = mode_ff;
      nl      = 1'b0;
      do_word = 1'b0;
      n       = '0;
      ent     = '0;
      unique case (mode_ff)
         MODE_SLASH: begin
            if (c == CH_SLASH) begin
               mode_in = MODE_COMMENT;
            end else begin
               ent[n[1:0]] = '{EV_BEGIN, KIND_WORD, 8'h00};
               n = n + 3'd1;
               ent[n[1:0]] = '{EV_CONTENT, KIND_WORD, CH_SLASH};
               n = n + 3'd1;
               do_word = 1'b1;
            end
         end
         MODE_COMMENT: begin
            if (c == CH_EOT) begin
               ent[n[1:0]] = '{EV_EOT, KIND_WORD, 8'h00};
               n = n + 3'd1;
               mode_in = MODE_IDLE;
            end else if (c == CH_NL) begin
               nl = 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_WORD: begin
            do_word = 1'b1;
         end
         MODE_QUOTED: begin
            if (c == CH_EOT) begin
               ent[n[1:0]] = '{EV_END, KIND_QUOTED, 8'h00};
               n = n + 3'd1;
               ent[n[1:0]] = '{EV_EOT, KIND_WORD, 8'h00};
               n = n + 3'd1;
               mode_in = MODE_IDLE;
            end else if (c == CH_QUOTE) begin
               ent[n[1:0]] = '{EV_END, KIND_QUOTED, 8'h00};
               n = n + 3'd1;
               mode_in = MODE_IDLE;
            end else begin
               ent[n[1:0]] = '{EV_CONTENT, KIND_QUOTED, c};
               n = n + 3'd1;
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            if (c == CH_EOT) begin
               ent[n[1:0]] = '{EV_EOT, KIND_WORD, 8'h00};
               n = n + 3'd1;
            end else if (c == CH_NL) begin
               nl = 1'b1;
            end else if (is_space(c)) begin
               mode_in = MODE_IDLE;
            end else if (c == CH_SLASH) begin
               mode_in = MODE_SLASH;
            end else if (bk != KIND_WORD) begin
               ent[n[1:0]] = '{EV_BEGIN, bk, 8'h00};
               n = n + 3'd1;
            end else if (c == CH_QUOTE) begin
               ent[n[1:0]] = '{EV_BEGIN, KIND_QUOTED, 8'h00};
               n = n + 3'd1;
               mode_in = MODE_QUOTED;
            end else begin
               ent[n[1:0]] = '{EV_BEGIN, KIND_WORD, 8'h00};
               n = n + 3'd1;
               ent[n[1:0]] = '{EV_CONTENT, KIND_WORD, c};
               n = n + 3'd1;
               mode_in = MODE_WORD;
            end
         end
      endcase

      // byte seen while a word is open
      if (do_word) begin
         if (c == CH_EOT) begin
            ent[n[1:0]] = '{EV_END, KIND_WORD, 8'h00};
            n = n + 3'd1;
            ent[n[1:0]] = '{EV_EOT, KIND_WORD, 8'h00};
            n = n + 3'd1;
            mode_in = MODE_IDLE;
         end else if (is_space(c)) begin
            ent[n[1:0]] = '{EV_END, KIND_WORD, 8'h00};
            n = n + 3'd1;
            nl = (c == CH_NL);
            mode_in = MODE_IDLE;
         end else if (bk != KIND_WORD) begin
            ent[n[1:0]] = '{EV_END, KIND_WORD, 8'h00};
            n = n + 3'd1;
            ent[n[1:0]] = '{EV_BEGIN, bk, 8'h00};
            n = n + 3'd1;
            mode_in = MODE_IDLE;
         end else if (c == CH_QUOTE) begin
            ent[n[1:0]] = '{EV_END, KIND_WORD, 8'h00};
            n = n + 3'd1;
            ent[n[1:0]] = '{EV_BEGIN, KIND_QUOTED, 8'h00};
            n = n + 3'd1;
            mode_in = MODE_QUOTED;
         end else begin
            ent[n[1:0]] = '{EV_CONTENT, KIND_WORD, c};
            n = n + 3'd1;
            mode_in = MODE_WORD;
         end
      end
   end

   // saturating line counter
   always_comb begin
      line_in = line_ff;
      if (accept && nl && (line_ff != '1)) begin
         line_in = line_ff + 1'b1;
      end
   end

   assign q_push         = accept && (n != '0);
   assign q_bundle.ent   = ent;
   assign q_bundle.count = n;
   assign q_bundle.line  = line_rep;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         line_ff <= LINE_BITS'(1);
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
         end
         if (csr_wen) begin
            line_ff <= LINE_BITS'(csr_wdata);
         end else begin
            line_ff <= line_in;
         end
      end
   end

endmodule

### rtl/core/mtt_back.sv
// back: walks each bundle one result item per cycle into the output register unless stalled by rsp_tready
module mtt_back import mtt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  bundle_type  q_bundle,
   output logic        q_pop,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,
   output logic [4:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int IDX_W = $clog2(MAX_EV);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   entry_type        ent_ff, ent_in;
   logic [LINE_W-1:0] line_ff, line_in;
   logic             last_ff, last_in;
   logic             load;
   logic             is_last;

   assign load    = q_valid && (!valid_ff || rsp_tready);
   assign is_last = (3'({1'b0, idx_ff}) + 3'd1) == q_bundle.count;
   assign q_pop   = load && is_last;

   // next output register contents
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      ent_in   = ent_ff;
      line_in  = line_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         ent_in   = q_bundle.ent[idx_ff];
         line_in  = q_bundle.line;
         last_in  = is_last;
         idx_in   = is_last ? '0 : idx_ff + 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff  <= ent_in;
      line_ff <= line_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {line_ff, ent_ff.data};
   assign rsp_tuser  = {ent_ff.token_kind, ent_ff.event_res};
   assign rsp_tlast  = last_ff;

endmodule
